// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the timestamp parser, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)
`define ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif
`endif

// ===== hdl/tsp_pkg.sv =====
// Shared types, constants and functions of the timestamp parser.
package tsp_pkg;

  localparam int HOURS_W     = 22;
  localparam int MINSEC_W    = 7;
  localparam int FRAC_W      = 30;
  localparam int FCNT_W      = 4;
  localparam int SECS_W      = 34;
  localparam int TIME_W      = 63;
  localparam int MUL_W       = 30;
  localparam int SPLIT_W     = 17;

  localparam int DEF_MAX_HOURS       = 2562046;
  localparam int DEF_FRACTION_DIGITS = 9;
  localparam int FRAC_DIGITS_MAX     = 9;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [MINSEC_W-1:0] MINSEC_LIMIT = MINSEC_W'(60);
  localparam logic [MUL_W-1:0]    SEC_PER_HOUR = MUL_W'(3600);
  localparam logic [MUL_W-1:0]    NS_PER_SEC   = MUL_W'(1000000000);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_FMT = 2'd1,
    STATUS_OVF = 2'd2
  } status_t;

  // One finished text, handed from the parser to the arithmetic back end.
  typedef struct packed {
    status_t               status;
    logic [HOURS_W-1:0]    hours;
    logic [MINSEC_W-1:0]   minutes;
    logic [MINSEC_W-1:0]   seconds;
    logic [FRAC_W-1:0]     fraction;
    logic [FCNT_W-1:0]     frac_count;
  } tsp_rec_t;

  // Power of ten that lifts a fraction with the given count of missing digits to ns.
  function automatic logic [MUL_W-1:0] pow10(input logic [FCNT_W-1:0] idx);
    logic [MUL_W-1:0] p;
    unique case (idx)
      4'd0:    p = MUL_W'(1);
      4'd1:    p = MUL_W'(10);
      4'd2:    p = MUL_W'(100);
      4'd3:    p = MUL_W'(1000);
      4'd4:    p = MUL_W'(10000);
      4'd5:    p = MUL_W'(100000);
      4'd6:    p = MUL_W'(1000000);
      4'd7:    p = MUL_W'(10000000);
      4'd8:    p = MUL_W'(100000000);
      4'd9:    p = MUL_W'(1000000000);
      default: p = MUL_W'(1);
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/tsp_front.sv =====
// Character parser: walks the grammar one character per cycle while accept is high and emits a record at NUL.
module tsp_front import tsp_pkg::*; #(
  parameter int MAX_HOURS       = DEF_MAX_HOURS,
  parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  output logic       rec_push,
  output tsp_rec_t   rec
);

  typedef enum logic [9:0] {
    PH_LEAD       = 10'b00_0000_0001,
    PH_HOURS      = 10'b00_0000_0010,
    PH_MIN_FIRST  = 10'b00_0000_0100,
    PH_MIN        = 10'b00_0000_1000,
    PH_SEC_FIRST  = 10'b00_0001_0000,
    PH_SEC        = 10'b00_0010_0000,
    PH_FRAC_FIRST = 10'b00_0100_0000,
    PH_FRAC       = 10'b00_1000_0000,
    PH_TRAIL      = 10'b01_0000_0000,
    PH_SINK       = 10'b10_0000_0000
  } phase_t;

  localparam logic [HOURS_W-1:0] HOURS_CAP  = HOURS_W'(MAX_HOURS + 1);
  localparam logic [HOURS_W-1:0] HOURS_MAX  = HOURS_W'(MAX_HOURS);
  localparam logic [FCNT_W-1:0]  FRAC_LIMIT = FCNT_W'(FRACTION_DIGITS);

  phase_t              phase, phase_next;
  logic [HOURS_W-1:0]  hours, hours_next;
  logic [MINSEC_W-1:0] minutes, minutes_next;
  logic [MINSEC_W-1:0] seconds, seconds_next;
  logic [FRAC_W-1:0]   fraction, fraction_next;
  logic [FCNT_W-1:0]   frac_count, frac_count_next;

  logic       is_digit, is_blank, is_nul, is_sep;
  logic [3:0] digit;
  logic       ended_ok;

  // Decimal accumulate that sticks at the cap once reached.
  function automatic logic [HOURS_W-1:0] add_sat(input logic [HOURS_W-1:0] acc,
                                                 input logic [3:0] d,
                                                 input logic [HOURS_W-1:0] cap);
    logic [HOURS_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (HOURS_W+4)'(d);
    if (acc >= cap || v >= {4'b0, cap}) return cap;
    return v[HOURS_W-1:0];
  endfunction

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign is_sep   = (char_code == CH_DOT) || (char_code == CH_COMMA);
  assign is_nul   = (char_code == CH_NUL);
  assign digit    = char_code[3:0];
  assign ended_ok = (phase == PH_SEC) || (phase == PH_FRAC) || (phase == PH_TRAIL);

  always_comb begin
    phase_next      = phase;
    hours_next      = hours;
    minutes_next    = minutes;
    seconds_next    = seconds;
    fraction_next   = fraction;
    frac_count_next = frac_count;
    if (is_nul) begin
      phase_next      = PH_LEAD;
      hours_next      = '0;
      minutes_next    = '0;
      seconds_next    = '0;
      fraction_next   = '0;
      frac_count_next = '0;
    end else begin
      unique case (phase)
        PH_LEAD: begin
          if (is_digit) begin
            hours_next = HOURS_W'(digit);
            phase_next = PH_HOURS;
          end else if (!is_blank) begin
            phase_next = PH_SINK;
          end
        end
        PH_HOURS: begin
          if (is_digit) hours_next = add_sat(hours, digit, HOURS_CAP);
          else if (char_code == CH_COLON) phase_next = PH_MIN_FIRST;
          else phase_next = PH_SINK;
        end
        PH_MIN_FIRST, PH_MIN: begin
          if (is_digit) begin
            minutes_next = MINSEC_W'(add_sat(HOURS_W'(minutes), digit, HOURS_W'(MINSEC_LIMIT)));
            phase_next   = PH_MIN;
          end else if (char_code == CH_COLON && phase == PH_MIN) begin
            phase_next = PH_SEC_FIRST;
          end else begin
            phase_next = PH_SINK;
          end
        end
        PH_SEC_FIRST, PH_SEC: begin
          if (is_digit) begin
            seconds_next = MINSEC_W'(add_sat(HOURS_W'(seconds), digit, HOURS_W'(MINSEC_LIMIT)));
            phase_next   = PH_SEC;
          end else if (phase == PH_SEC && is_sep) begin
            phase_next = PH_FRAC_FIRST;
          end else if (phase == PH_SEC && is_blank) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_SINK;
          end
        end
        PH_FRAC_FIRST, PH_FRAC: begin
          if (is_digit) begin
            if (frac_count < FRAC_LIMIT) begin
              fraction_next   = (fraction << 3) + (fraction << 1) + FRAC_W'(digit);
              frac_count_next = frac_count + 1'b1;
            end
            phase_next = PH_FRAC;
          end else if (phase == PH_FRAC && is_blank) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_SINK;
          end
        end
        PH_TRAIL: begin
          if (!is_blank) phase_next = PH_SINK;
        end
        default: phase_next = PH_SINK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      hours      <= '0;
      minutes    <= '0;
      seconds    <= '0;
      fraction   <= '0;
      frac_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      hours      <= hours_next;
      minutes    <= minutes_next;
      seconds    <= seconds_next;
      fraction   <= fraction_next;
      frac_count <= frac_count_next;
    end
  end

  // The record is built from the state as it stands when the terminator arrives.
  assign rec_push = accept && is_nul;

  always_comb begin
    rec.hours      = hours;
    rec.minutes    = minutes;
    rec.seconds    = seconds;
    rec.fraction   = fraction;
    rec.frac_count = frac_count;
    if (!ended_ok || minutes >= MINSEC_LIMIT || seconds >= MINSEC_LIMIT) rec.status = STATUS_FMT;
    else if (hours > HOURS_MAX) rec.status = STATUS_OVF;
    else rec.status = STATUS_OK;
  end

endmodule

// ===== hdl/tsp_queue.sv =====
// Short record queue that decouples the parser from the arithmetic back end.
module tsp_queue import tsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  tsp_rec_t wr_rec,
  input  logic     rd_en,
  output tsp_rec_t rd_rec,
  output logic     q_full,
  output logic     q_empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  tsp_rec_t        slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign q_full  = (count == CW'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_rec  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/tsp_back.sv =====
// Arithmetic back end: turns a parsed record into nanoseconds with one shared multiplier.
module tsp_back import tsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  tsp_rec_t          q_rec,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [1:0]        status,
  output logic [TIME_W-1:0] time_ns
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_FRAC = 7'b000_0010,
    ST_HRS  = 7'b000_0100,
    ST_SECS = 7'b000_1000,
    ST_LO   = 7'b001_0000,
    ST_HI   = 7'b010_0000,
    ST_DONE = 7'b100_0000
  } step_t;

  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = MUL_W + SPLIT_W + 1;

  step_t               step, step_next;
  logic [HOURS_W-1:0]  r_hours;
  logic [MINSEC_W-1:0] r_min;
  logic [MINSEC_W-1:0] r_sec;
  logic [FRAC_W-1:0]   r_frac;
  logic [FCNT_W-1:0]   r_cnt;
  logic [FRAC_W-1:0]   frac_ns;
  logic [SECS_W-1:0]   secs;
  logic [ACC_W-1:0]    acc;
  logic [PROD_W-1:0]   prod;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic                out_valid;
  logic                slot_free;
  logic                take_rec;
  logic [TIME_W:0]     total;

  assign slot_free = !out_valid || pop;
  // An erroneous record needs no arithmetic and goes straight to the output slot.
  assign take_rec  = (step == ST_IDLE) && !q_empty &&
                     ((q_rec.status == STATUS_OK) || slot_free);
  assign q_pop     = take_rec;
  assign empty     = !out_valid;

  always_comb begin
    unique case (step)
      ST_FRAC: begin
        mul_a = r_frac;
        mul_b = pow10(FCNT_W'(FRAC_DIGITS_MAX) - r_cnt);
      end
      ST_HRS: begin
        mul_a = MUL_W'(r_hours);
        mul_b = SEC_PER_HOUR;
      end
      ST_LO: begin
        mul_a = MUL_W'(secs[SPLIT_W-1:0]);
        mul_b = NS_PER_SEC;
      end
      ST_HI: begin
        mul_a = MUL_W'(secs[SECS_W-1:SPLIT_W]);
        mul_b = NS_PER_SEC;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign total = (TIME_W+1)'(acc) + ((TIME_W+1)'(prod[MUL_W+SPLIT_W-1:0]) << SPLIT_W);

  always_comb begin
    step_next = step;
    unique case (step)
      ST_IDLE: if (take_rec && q_rec.status == STATUS_OK) step_next = ST_FRAC;
      ST_FRAC: step_next = ST_HRS;
      ST_HRS:  step_next = ST_SECS;
      ST_SECS: step_next = ST_LO;
      ST_LO:   step_next = ST_HI;
      ST_HI:   step_next = ST_DONE;
      ST_DONE: if (slot_free) step_next = ST_IDLE;
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if ((take_rec && q_rec.status != STATUS_OK) || (step == ST_DONE && slot_free)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_rec) begin
      r_hours <= q_rec.hours;
      r_min   <= q_rec.minutes;
      r_sec   <= q_rec.seconds;
      r_frac  <= q_rec.fraction;
      r_cnt   <= q_rec.frac_count;
    end
    if (step == ST_FRAC || step == ST_HRS || step == ST_LO || step == ST_HI) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (step == ST_HRS) frac_ns <= prod[FRAC_W-1:0];
    if (step == ST_SECS) begin
      secs <= prod[SECS_W-1:0] + SECS_W'(r_min) * SECS_W'(60) + SECS_W'(r_sec);
    end
    if (step == ST_HI) acc <= ACC_W'(prod[MUL_W+SPLIT_W-1:0]) + ACC_W'(frac_ns);
    if (take_rec && q_rec.status != STATUS_OK) begin
      status  <= q_rec.status;
      time_ns <= '0;
    end else if (step == ST_DONE && slot_free) begin
      status  <= STATUS_OK;
      time_ns <= total[TIME_W-1:0];
    end
  end

endmodule

// ===== hdl/timestamp_text_parser.sv =====
// Top level of the streaming hh:mm:ss[.fraction] timestamp parser.
//
// The block takes one character per transfer on push/full and answers each
// NUL-terminated text with one result on empty/pop: a status (ok, format
// error, hours overflow) and the time in nanoseconds, which is zero unless the
// status is ok. Characters are taken one per clock cycle with no gaps while
// the parser runs; the parser only stalls (full high) when its two-entry record
// queue is full. Each terminator hands a record to the back end. An ok text
// holds the back end for a step that takes the record, five arithmetic steps
// (fraction scaling, hours to seconds, seconds summation, and two halves of
// the seconds-to-nanoseconds product, all but the summation on the shared
// 30x30 multiplier) and a step that hands the result to the output register
// once it is free. An erroneous text needs no arithmetic step. Long texts run
// at one character per cycle while the queue has room; a burst of very short
// texts is limited by the back end, which takes a new record only from its
// idle step. A finished result waits in the output register while the next
// text is already being parsed. MAX_HOURS sets the largest accepted hours
// value and FRACTION_DIGITS how many fraction digits count; further digits
// are ignored.
module timestamp_text_parser import tsp_pkg::*; #(
  parameter int MAX_HOURS       = DEF_MAX_HOURS,
  parameter int FRACTION_DIGITS = DEF_FRACTION_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        char_code,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic [TIME_W-1:0] time_ns
);

`include "assert_macros.svh"

  logic     accept;
  logic     rec_push;
  logic     rec_pop;
  logic     q_full;
  logic     q_empty;
  tsp_rec_t front_rec;
  tsp_rec_t back_rec;

  // A character transfer completes whenever the queue has room for a record.
  assign full   = q_full;
  assign accept = push && !q_full;

  tsp_front #(
    .MAX_HOURS       (MAX_HOURS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  tsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_rec  (front_rec),
    .rd_en   (rec_pop),
    .rd_rec  (back_rec),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rec   (back_rec),
    .q_pop   (rec_pop),
    .pop     (pop),
    .empty   (empty),
    .status  (status),
    .time_ns (time_ns)
  );

  // A failed text must never report a time.
  `ASSERT_IMPLIES(a_err_zero_time, clk, rst, !empty && status != STATUS_OK, time_ns == '0, "non-ok result carries a time")
  // Only defined status codes reach the result port.
  `ASSERT_IMPLIES(a_status_code, clk, rst, !empty, status == STATUS_OK || status == STATUS_FMT || status == STATUS_OVF, "undefined status code")
  // The back end never reads a record that is not there.
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, rec_pop, !q_empty, "record read from empty queue")
  // A record written into a queue with no room would be lost.
  `ASSERT_IMPLIES(a_push_room, clk, rst, rec_push, !q_full, "record written into full queue")
  // Once a result is shown and not taken, it is still shown next cycle.
  `ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty, "result dropped without a transfer")

endmodule

// ===== dv/timestamp_text_parser_tb.sv =====
// Self-checking testbench of the streaming hh:mm:ss[.fraction] timestamp parser.
module timestamp_text_parser_tb;
  import tsp_pkg::*;

  // Parser phases of the predictor. They mirror the grammar: leading blanks,
  // hours, the first and further minute digits, the first and further second
  // digits, the first and further fraction digits, trailing blanks, and a sink
  // phase that swallows everything after a format error.
  typedef enum logic [3:0] {
    PH_LEAD, PH_HOURS, PH_MIN_FIRST, PH_MIN, PH_SEC_FIRST, PH_SEC,
    PH_FRAC_FIRST, PH_FRAC, PH_TRAIL, PH_SINK
  } phase_e;

  // One parsed timestamp as the block reports it.
  typedef struct {
    status_t            st;
    logic [TIME_W-1:0]  ns;
  } stamp_t;

  // One directed text. When known is set, the expected stamp is written out
  // in the row; otherwise the predictor supplies it.
  typedef struct {
    string              txt;
    bit                 known;
    status_t            st;
    logic [TIME_W-1:0]  ns;
  } text_row_t;

  localparam int          NUM_ROWS   = 22;
  localparam int unsigned HOURS_CAP  = DEF_MAX_HOURS + 1;
  localparam int          RAND_CHARS = 1900;

  logic              clk;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        char_code = 8'h00;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        status;
  logic [TIME_W-1:0] time_ns;

  timestamp_text_parser dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .time_ns   (time_ns)
  );

  // Directed texts. The terminating NUL is appended by the loop that walks
  // the table, so the empty string is a text made of the terminator alone.
  text_row_t text_rows [NUM_ROWS] = '{
    '{"",                        1'b1, STATUS_FMT, 63'd0},
    '{"0:0:0",                   1'b1, STATUS_OK,  63'd0},
    '{"2562046:59:59.999999999", 1'b1, STATUS_OK,  63'd9223369199999999999},
    '{"2562047:0:0",             1'b1, STATUS_OVF, 63'd0},
    '{"123456789:00:00",         1'b1, STATUS_OVF, 63'd0},
    '{"0:60:0",                  1'b1, STATUS_FMT, 63'd0},
    '{"0:0:60",                  1'b1, STATUS_FMT, 63'd0},
    '{"1:2",                     1'b1, STATUS_FMT, 63'd0},
    '{":1:2",                    1'b1, STATUS_FMT, 63'd0},
    '{"1::2",                    1'b1, STATUS_FMT, 63'd0},
    '{"1:2:",                    1'b1, STATUS_FMT, 63'd0},
    '{"1:2:3.",                  1'b1, STATUS_FMT, 63'd0},
    '{"1:2:3x",                  1'b1, STATUS_FMT, 63'd0},
    '{"\377",                    1'b1, STATUS_FMT, 63'd0},
    '{"1:2:3 4",                 1'b1, STATUS_FMT, 63'd0},
    '{"9999999:99:0",            1'b1, STATUS_FMT, 63'd0},
    '{"1:2:3.\t",                1'b1, STATUS_FMT, 63'd0},
    '{"0 :1:2",                  1'b1, STATUS_FMT, 63'd0},
    '{" \t07:08:09",             1'b0, STATUS_OK,  63'd0},
    '{"1:2:3,1234567891234 \t",  1'b0, STATUS_OK,  63'd0},
    '{"23:59:59.5 ",             1'b0, STATUS_OK,  63'd0},
    '{"1:2:3.05",                1'b0, STATUS_OK,  63'd0}
  };

  // Predictor state: the parse of the text in flight.
  phase_e      ph;
  int unsigned hrs_acc, min_acc, sec_acc, frac_acc, frac_cnt;
  bit          fmt_bad;

  // Stamps the block still owes, oldest first.
  stamp_t pending_stamps [$];

  int errors;
  int chars_sent;
  int texts_ok, texts_fmt, texts_ovf;
  int send_idle_pct;
  int pop_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run. A correct run ends far sooner.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // Decimal accumulation that sticks at the cap once it reaches it.
  function automatic int unsigned add_digit_capped(input int unsigned acc,
                                                   input int unsigned d,
                                                   input int unsigned cap);
    int unsigned v;
    v = acc * 10 + d;
    return (acc >= cap || v >= cap) ? cap : v;
  endfunction

  task automatic clear_parse();
    ph       = PH_LEAD;
    hrs_acc  = 0;
    min_acc  = 0;
    sec_acc  = 0;
    frac_acc = 0;
    frac_cnt = 0;
    fmt_bad  = 1'b0;
  endtask

  task automatic flag_format();
    fmt_bad = 1'b1;
    ph      = PH_SINK;
  endtask

  // Advances the parse by one character. A NUL closes the text and yields the
  // stamp the block must report for it.
  task automatic parse_char(input logic [7:0] c, output bit done, output stamp_t res);
    int unsigned d;
    longint unsigned scaled;
    bit ended_ok;
    d      = c - CH_ZERO;
    done   = 1'b0;
    res.st = STATUS_OK;
    res.ns = '0;
    if (c == CH_NUL) begin
      done     = 1'b1;
      ended_ok = ph == PH_SEC || ph == PH_FRAC || ph == PH_TRAIL;
      if (!ended_ok || fmt_bad || min_acc >= 60 || sec_acc >= 60) begin
        res.st = STATUS_FMT;
      end else if (hrs_acc > DEF_MAX_HOURS) begin
        res.st = STATUS_OVF;
      end else begin
        // Fewer than nine fraction digits means the value is scaled up to ns.
        scaled = frac_acc;
        for (int i = frac_cnt; i < 9; i++) scaled = scaled * 10;
        res.ns = TIME_W'((longint'(hrs_acc) * 3600 + min_acc * 60 + sec_acc)
                 * 64'd1000000000 + scaled);
      end
      clear_parse();
    end else begin
      case (ph)
        PH_LEAD: begin
          if (is_digit(c)) begin
            hrs_acc = d;
            ph      = PH_HOURS;
          end else if (!is_blank(c)) begin
            flag_format();
          end
        end
        PH_HOURS: begin
          if (is_digit(c)) hrs_acc = add_digit_capped(hrs_acc, d, HOURS_CAP);
          else if (c == CH_COLON) ph = PH_MIN_FIRST;
          else flag_format();
        end
        PH_MIN_FIRST, PH_MIN: begin
          if (is_digit(c)) begin
            min_acc = add_digit_capped(min_acc, d, 60);
            ph      = PH_MIN;
          end else if (c == CH_COLON && ph == PH_MIN) begin
            ph = PH_SEC_FIRST;
          end else begin
            flag_format();
          end
        end
        PH_SEC_FIRST, PH_SEC: begin
          if (is_digit(c)) begin
            sec_acc = add_digit_capped(sec_acc, d, 60);
            ph      = PH_SEC;
          end else if (ph == PH_SEC && (c == CH_DOT || c == CH_COMMA)) begin
            ph = PH_FRAC_FIRST;
          end else if (ph == PH_SEC && is_blank(c)) begin
            ph = PH_TRAIL;
          end else begin
            flag_format();
          end
        end
        PH_FRAC_FIRST, PH_FRAC: begin
          if (is_digit(c)) begin
            // Digits past the counted ones are accepted but dropped.
            if (frac_cnt < DEF_FRACTION_DIGITS) begin
              frac_acc = frac_acc * 10 + d;
              frac_cnt++;
            end
            ph = PH_FRAC;
          end else if (ph == PH_FRAC && is_blank(c)) begin
            ph = PH_TRAIL;
          end else begin
            flag_format();
          end
        end
        PH_TRAIL: begin
          if (!is_blank(c)) flag_format();
        end
        default: flag_format();
      endcase
    end
  endtask

  // Offers one character and waits for its transfer. Idle cycles are drawn
  // one at a time, so gaps land before any character of a text, including the
  // terminator. When known is set, the stamp given by the caller replaces the
  // predicted one for a terminator.
  task automatic send_char(input logic [7:0] c, input bit known, input stamp_t given);
    bit done;
    stamp_t res;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (full);
    chars_sent++;
    parse_char(c, done, res);
    if (done) pending_stamps.push_back(known ? given : res);
  endtask

  task automatic send_text(input string txt, input bit known, input stamp_t given);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], 1'b0, given);
    send_char(CH_NUL, known, given);
  endtask

  // Holds the sender off until the block has delivered every owed stamp.
  task automatic drain_results();
    push <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic string digit_run(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  function automatic string blank_run();
    string s;
    int n;
    s = "";
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      s = {s, ($urandom_range(0, 1) != 0) ? string'(" ") : string'("\t")};
    end
    return s;
  endfunction

  // Minutes or seconds: mostly in range, sometimes 60 and up, sometimes padded.
  function automatic string minsec_field();
    int unsigned v;
    if ($urandom_range(0, 99) < 85) v = $urandom_range(0, 59);
    else if ($urandom_range(0, 1) != 0) v = $urandom_range(60, 99);
    else v = $urandom_range(100, 99999);
    return ($urandom_range(0, 1) != 0) ? $sformatf("%02d", v) : $sformatf("%0d", v);
  endfunction

  // A timestamp text with random content. Most are well formed; about a
  // quarter are damaged by a replaced, dropped or inserted character or a
  // cut, and a few are plain noise.
  function automatic string random_text();
    string s;
    int unsigned hrs, pos;
    int n;
    if ($urandom_range(0, 99) < 6) begin
      s = "";
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
      return s;
    end
    case ($urandom_range(0, 3))
      0:       hrs = $urandom_range(0, 99);
      1:       hrs = $urandom_range(0, 99999);
      2:       hrs = DEF_MAX_HOURS - 2 + $urandom_range(0, 4);
      default: hrs = $urandom_range(0, 999999999);
    endcase
    s = blank_run();
    s = {s, ($urandom_range(0, 3) == 0) ? $sformatf("%05d", hrs) : $sformatf("%0d", hrs)};
    s = {s, ":", minsec_field(), ":", minsec_field()};
    if ($urandom_range(0, 99) < 60) begin
      s = {s, ($urandom_range(0, 1) != 0) ? string'(".") : string'(","),
           digit_run($urandom_range(1, 12))};
    end
    if ($urandom_range(0, 2) == 0) s = {s, blank_run()};
    if ($urandom_range(0, 99) < 25) begin
      pos = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 3))
        0: s[pos] = 8'($urandom_range(1, 255));
        1: s = {s.substr(0, int'(pos) - 1), s.substr(pos + 1, s.len() - 1)};
        2: s = s.substr(0, int'(pos) - 1);
        default: s = $sformatf("%s%c%s", s.substr(0, int'(pos) - 1),
                               8'($urandom_range(1, 255)), s.substr(pos, s.len() - 1));
      endcase
    end
    return s;
  endfunction

  task automatic random_phase(input int sidle, input int pstall, input int n_chars);
    int target;
    stamp_t unused;
    unused.st     = STATUS_OK;
    unused.ns     = '0;
    send_idle_pct = sidle;
    pop_stall_pct = pstall;
    target        = chars_sent + n_chars;
    while (chars_sent < target) send_text(random_text(), 1'b0, unused);
  endtask

  // Result side: checks each transfer against the oldest owed stamp and draws
  // the pop for the next cycle.
  always @(posedge clk) begin
    stamp_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_stamps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d time_ns=%0d", $time, status, time_ns);
        end else begin
          want = pending_stamps.pop_front();
          if (status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          end
          if (time_ns !== want.ns) begin
            errors++;
            $display("%0t: time_ns expected %0d actual %0d", $time, want.ns, time_ns);
          end
          case (want.st)
            STATUS_OK:  texts_ok++;
            STATUS_FMT: texts_fmt++;
            default:    texts_ovf++;
          endcase
        end
      end
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  initial begin
    stamp_t row_stamp;
    errors        = 0;
    chars_sent    = 0;
    texts_ok      = 0;
    texts_fmt     = 0;
    texts_ovf     = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    clear_parse();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts with light idling on both sides.
    send_idle_pct = 26;
    pop_stall_pct = 26;
    foreach (text_rows[i]) begin
      row_stamp.st = text_rows[i].st;
      row_stamp.ns = text_rows[i].ns;
      send_text(text_rows[i].txt, text_rows[i].known, row_stamp);
    end

    // Random texts in four idling mixes. Before the receiver-stall mix the
    // sender waits until every owed stamp has come back.
    random_phase(0, 0, RAND_CHARS / 4);
    random_phase(64, 0, RAND_CHARS / 4);
    drain_results();
    random_phase(0, 64, RAND_CHARS / 4);
    random_phase(26, 26, RAND_CHARS / 4);

    // Let the back end finish the last text and catch any stray result.
    drain_results();
    repeat (32) @(posedge clk);

    $display("Sent %0d characters over four idle mixes.", chars_sent);
    $display("Results checked: %0d ok, %0d format error, %0d hours overflow.",
             texts_ok, texts_fmt, texts_ovf);
    if (errors == 0 && pending_stamps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsp_pkg.sv
hdl/tsp_front.sv
hdl/tsp_queue.sv
hdl/tsp_back.sv
hdl/timestamp_text_parser.sv
dv/timestamp_text_parser_tb.sv
